// File: rtl/atwss_pkg.sv
// Shared types and constants for the adaptive two-way signal scheduler.
// Holds beat structs, state codes, result codes and register reset values.
// No dependencies.
package atwss_pkg;

  // Field widths and default lane depth
  localparam int ID_BITS        = 16;
  localparam int LANE_DEPTH_DEF = 32;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 7;

  // Register reset values
  localparam logic [6:0] CAPACITY_RST  = 7'd15;
  localparam logic [3:0] LOAD_RST      = 4'd7;
  localparam logic [5:0] IMB_LIMIT_RST = 6'd3;
  localparam logic [3:0] BASE_G_RST    = 4'd2;
  localparam logic [3:0] EMER_G_RST    = 4'd6;
  localparam logic [3:0] IMB_G_RST     = 4'd7;
  localparam logic [3:0] OVL_G_RST     = 4'd5;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_LANE_CAPACITY   = 3'd0,
    REG_LOAD_TENTHS     = 3'd1,
    REG_IMBALANCE_LIMIT = 3'd2,
    REG_BASE_GREEN      = 3'd3,
    REG_EMERGENCY_GREEN = 3'd4,
    REG_IMBALANCE_GREEN = 3'd5,
    REG_OVERLOAD_GREEN  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_DECISION = 2'd0,
    KIND_SERVED   = 2'd1,
    KIND_DROPPED  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CAUSE_ALTERNATION = 2'd0,
    CAUSE_EMERGENCY   = 2'd1,
    CAUSE_IMBALANCE   = 2'd2,
    CAUSE_OVERLOAD    = 2'd3
  } cause_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARRIVE,
    S_ORDER,
    S_LOAD,
    S_SPAN,
    S_DECIDE,
    S_FETCH,
    S_SERVE
  } state_t;

  typedef struct packed {
    logic               mode;
    logic               arrival_lane;
    logic [ID_BITS-1:0] car_id;
    logic               car_emergency;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               green_lane;
    logic [3:0]         green_count;
    logic [1:0]         cause;
    logic [ID_BITS-1:0] served_id;
    logic               served_emergency;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               emergency;
    logic [ID_BITS-1:0] id;
  } lane_entry_t;

endpackage

// File: rtl/adaptive_two_way_signal_scheduler.sv
// Top level of the adaptive two-way signal scheduler: lane memory, counters,
// decision sequencer around one shared comparator, and the config registers.
// Depends on atwss_pkg.
//
// Usage:
//  - Input beats: drive in_item and raise start; the beat is taken at an edge
//    with start high and busy low. busy drops as the final result goes out,
//    so the next beat can be taken at the edge that ends that result.
//  - Results: out_valid marks a beat of out_item for exactly one cycle; the
//    receiver cannot stall, so every result must be taken as it appears.
//    out_item.last flags the final result of an input beat.
//  - Config: cfg_valid/cfg_ready write channel with cfg_index and cfg_data;
//    cfg_ready is always high. Write only while busy is low.
//  - Sequence: an arrival is captured, then the lane write or drop report
//    follows in the next cycle. A signal cycle captures the beat, then makes
//    three passes through the shared comparator (lane order, overload test,
//    imbalance test) before the decision result; the imbalance pass is
//    skipped when the overload test hits. Each served car then needs a
//    registered lane memory read before its result goes out.
//  - Reset (rst_n low, synchronous): lanes empty, alarms and phase cleared,
//    registers at their defaults. Lane memory needs no clearing pass.
module adaptive_two_way_signal_scheduler #(
  parameter int LANE_DEPTH = atwss_pkg::LANE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  atwss_pkg::in_item_t                  in_item,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [atwss_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [atwss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                                 out_valid,
  output atwss_pkg::out_item_t                 out_item
);
  import atwss_pkg::*;

  localparam int PW    = $clog2(LANE_DEPTH);
  localparam int CW    = $clog2(LANE_DEPTH + 1);
  localparam int AW    = PW + 1;
  localparam int MEM_N = 2 ** AW;
  localparam int CMP_W = (CW + 5 > 11) ? CW + 5 : 11;
  localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(LANE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C  = CW'(LANE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(LANE_DEPTH - 1);

  // Config registers
  logic [6:0] capacity_r;
  logic [3:0] load_r;
  logic [5:0] imb_limit_r;
  logic [3:0] base_g_r, emer_g_r, imb_g_r, ovl_g_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAPACITY_RST;
      load_r      <= LOAD_RST;
      imb_limit_r <= IMB_LIMIT_RST;
      base_g_r    <= BASE_G_RST;
      emer_g_r    <= EMER_G_RST;
      imb_g_r     <= IMB_G_RST;
      ovl_g_r     <= OVL_G_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LANE_CAPACITY:   capacity_r  <= cfg_data;
        REG_LOAD_TENTHS:     load_r      <= cfg_data[3:0];
        REG_IMBALANCE_LIMIT: imb_limit_r <= cfg_data[5:0];
        REG_BASE_GREEN:      base_g_r    <= cfg_data[3:0];
        REG_EMERGENCY_GREEN: emer_g_r    <= cfg_data[3:0];
        REG_IMBALANCE_GREEN: imb_g_r     <= cfg_data[3:0];
        REG_OVERLOAD_GREEN:  ovl_g_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Control and lane state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_ns_r, cnt_ns_nxt, cnt_ew_r, cnt_ew_nxt;
  logic [PW-1:0]   head_ns_r, head_ns_nxt, head_ew_r, head_ew_nxt;
  logic            alarm_ns_r, alarm_ns_nxt, alarm_ew_r, alarm_ew_nxt;
  logic            phase_r, phase_nxt;
  logic            sel_r, sel_nxt;
  logic            ns_gt_r, ns_gt_nxt;
  logic [3:0]      green_r, green_nxt;
  logic [3:0]      left_r, left_nxt;
  cause_t          cause_r, cause_nxt;
  in_item_t        item_r, item_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_item_r, out_item_nxt;

  // Lane memory: lane bit on top of the slot pointer
  lane_entry_t     mem [MEM_N];
  lane_entry_t     rd_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_wa, mem_ra;
  lane_entry_t     mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem[mem_ra];
    end
  end

  // Selected lane views
  logic [CW-1:0] cur_cnt;
  logic [PW-1:0] cur_head;
  logic [CW:0]   tail_sum;
  logic [PW-1:0] tail_ptr;
  logic [PW-1:0] head_inc;

  assign cur_cnt  = sel_r ? cnt_ew_r : cnt_ns_r;
  assign cur_head = sel_r ? head_ew_r : head_ns_r;
  assign tail_sum = (CW + 1)'(cur_head) + (CW + 1)'(cur_cnt);
  assign tail_ptr = (tail_sum >= DEPTH_X) ? PW'(tail_sum - DEPTH_X) : PW'(tail_sum);
  assign head_inc = (cur_head == PTR_LAST) ? '0 : cur_head + 1'b1;

  // Shared comparator: operands chosen by the sequencer step
  logic [CW:0]      total;
  logic [CW-1:0]    diff;
  logic [CMP_W-1:0] cmp_a, cmp_b;
  logic             cmp_gt;

  assign total = (CW + 1)'(cnt_ns_r) + (CW + 1)'(cnt_ew_r);
  assign diff  = ns_gt_r ? cnt_ns_r - cnt_ew_r : cnt_ew_r - cnt_ns_r;

  always_comb begin
    unique case (state_r)
      S_LOAD: begin
        cmp_a = (CMP_W'(total) << 3) + (CMP_W'(total) << 1);
        cmp_b = CMP_W'(11'(capacity_r) * 11'(load_r));
      end
      S_SPAN: begin
        cmp_a = CMP_W'(diff);
        cmp_b = CMP_W'(imb_limit_r);
      end
      default: begin
        cmp_a = CMP_W'(cnt_ns_r);
        cmp_b = CMP_W'(cnt_ew_r);
      end
    endcase
  end

  assign cmp_gt = cmp_a > cmp_b;

  // State register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_ns_r    <= '0;
      cnt_ew_r    <= '0;
      head_ns_r   <= '0;
      head_ew_r   <= '0;
      alarm_ns_r  <= 1'b0;
      alarm_ew_r  <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_ns_r    <= cnt_ns_nxt;
      cnt_ew_r    <= cnt_ew_nxt;
      head_ns_r   <= head_ns_nxt;
      head_ew_r   <= head_ew_nxt;
      alarm_ns_r  <= alarm_ns_nxt;
      alarm_ew_r  <= alarm_ew_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sel_r      <= sel_nxt;
    ns_gt_r    <= ns_gt_nxt;
    green_r    <= green_nxt;
    left_r     <= left_nxt;
    cause_r    <= cause_nxt;
    item_r     <= item_nxt;
    out_item_r <= out_item_nxt;
  end

  // Sequencer: next state, lane updates and result beats
  always_comb begin
    state_nxt     = state_r;
    cnt_ns_nxt    = cnt_ns_r;
    cnt_ew_nxt    = cnt_ew_r;
    head_ns_nxt   = head_ns_r;
    head_ew_nxt   = head_ew_r;
    alarm_ns_nxt  = alarm_ns_r;
    alarm_ew_nxt  = alarm_ew_r;
    phase_nxt     = phase_r;
    sel_nxt       = sel_r;
    ns_gt_nxt     = ns_gt_r;
    green_nxt     = green_r;
    left_nxt      = left_r;
    cause_nxt     = cause_r;
    item_nxt      = item_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_wa        = {sel_r, tail_ptr};
    mem_wd        = '{emergency: item_r.car_emergency, id: item_r.car_id};
    mem_re        = 1'b0;
    mem_ra        = {sel_r, cur_head};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt  = in_item;
          sel_nxt   = in_item.arrival_lane;
          state_nxt = in_item.mode ? S_ORDER : S_ARRIVE;
        end
      end

      // Push into the lane, or report the drop when full
      S_ARRIVE: begin
        state_nxt = S_IDLE;
        if (cur_cnt == DEPTH_C) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{kind: KIND_DROPPED, green_lane: sel_r, green_count: 4'd0,
                            cause: CAUSE_ALTERNATION, served_id: item_r.car_id,
                            served_emergency: item_r.car_emergency, last: 1'b1};
        end else begin
          mem_we = 1'b1;
          if (sel_r) begin
            cnt_ew_nxt   = cnt_ew_r + 1'b1;
            alarm_ew_nxt = alarm_ew_r | item_r.car_emergency;
          end else begin
            cnt_ns_nxt   = cnt_ns_r + 1'b1;
            alarm_ns_nxt = alarm_ns_r | item_r.car_emergency;
          end
        end
      end

      // Which lane is longer
      S_ORDER: begin
        ns_gt_nxt = cmp_gt;
        state_nxt = S_LOAD;
      end

      // Overload test
      S_LOAD: begin
        if (cmp_gt) begin
          green_nxt = ovl_g_r;
          cause_nxt = CAUSE_OVERLOAD;
          sel_nxt   = ~ns_gt_r;
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SPAN;
        end
      end

      // Imbalance test, then emergency, then alternation
      S_SPAN: begin
        state_nxt = S_DECIDE;
        if (cmp_gt) begin
          green_nxt = imb_g_r;
          cause_nxt = CAUSE_IMBALANCE;
          sel_nxt   = ~ns_gt_r;
        end else if (alarm_ns_r || alarm_ew_r) begin
          green_nxt = emer_g_r;
          cause_nxt = CAUSE_EMERGENCY;
          sel_nxt   = ~alarm_ns_r;
        end else begin
          phase_nxt = ~phase_r;
          green_nxt = base_g_r;
          cause_nxt = CAUSE_ALTERNATION;
          sel_nxt   = ~phase_r;
        end
      end

      // Decision beat
      S_DECIDE: begin
        out_valid_nxt = 1'b1;
        left_nxt      = green_r;
        out_item_nxt  = '{kind: KIND_DECISION, green_lane: sel_r, green_count: green_r,
                          cause: cause_r, served_id: '0, served_emergency: 1'b0,
                          last: (green_r == 4'd0) || (cur_cnt == '0)};
        state_nxt     = out_item_nxt.last ? S_IDLE : S_FETCH;
      end

      // Read the head car of the green lane
      S_FETCH: begin
        mem_re    = 1'b1;
        state_nxt = S_SERVE;
      end

      // Served beat, pop the head car
      S_SERVE: begin
        out_valid_nxt = 1'b1;
        left_nxt      = left_r - 1'b1;
        out_item_nxt  = '{kind: KIND_SERVED, green_lane: sel_r, green_count: green_r,
                          cause: cause_r, served_id: rd_q.id,
                          served_emergency: rd_q.emergency,
                          last: (left_r == 4'd1) || (cur_cnt == CW'(1))};
        if (sel_r) begin
          cnt_ew_nxt   = cnt_ew_r - 1'b1;
          head_ew_nxt  = head_inc;
          alarm_ew_nxt = alarm_ew_r & ~rd_q.emergency;
        end else begin
          cnt_ns_nxt   = cnt_ns_r - 1'b1;
          head_ns_nxt  = head_inc;
          alarm_ns_nxt = alarm_ns_r & ~rd_q.emergency;
        end
        state_nxt = out_item_nxt.last ? S_IDLE : S_FETCH;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_ns_r <= DEPTH_C) && (cnt_ew_r <= DEPTH_C))
    else $error("lane count above depth");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last) |-> (state_r == S_IDLE))
    else $error("final beat but sequencer still running");

  a_served_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.kind == KIND_SERVED) |-> $past(state_r) == S_SERVE)
    else $error("served beat without a lane pop");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.last) |-> (state_r == S_FETCH))
    else $error("non-final beat not followed by a fetch");

endmodule
